// ===== src/hpd_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the heading PD omni drive.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package hpd_pkg;

	// Defaults for the top-level parameters
	localparam int SINE_FRAC_BITS_DEF = 15;
	localparam int FIFO_DEPTH_DEF     = 4;

	localparam int NUM_WHEELS = 4;

	// Gyro fold: readings above the threshold have the offset taken off, so 401..809 wrap to negative error
	localparam int GYRO_FOLD_THRESH = 400;
	localparam int GYRO_FOLD_OFFSET = 810;

	// Angles in whole degrees
	localparam int QUARTER_TURN = 90;
	localparam int HALF_TURN    = 180;
	localparam int THREE_QUARTS = 270;
	localparam int FULL_TURN    = 360;
	localparam int SINE_ENTRIES = QUARTER_TURN + 1;

	// Per-wheel angle offset (mod 360) and negation
	localparam logic [8:0] WHEEL_OFFSET [NUM_WHEELS] = '{9'd300, 9'd60, 9'd225, 9'd135};
	localparam logic [NUM_WHEELS-1:0] WHEEL_NEGATE = 4'b0101;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_P_GAIN    = 2'd0,
		CFG_D_GAIN    = 2'd1,
		CFG_CORR_LIM  = 2'd2,
		CFG_MOTOR_LIM = 2'd3
	} cfg_idx_t;

	localparam logic [15:0] P_GAIN_RST    = 16'd5898;
	localparam logic [3:0]  D_GAIN_RST    = 4'd1;
	localparam logic [6:0]  CORR_LIM_RST  = 7'd25;
	localparam logic [6:0]  MOTOR_LIM_RST = 7'd50;

	typedef struct packed {
		logic [15:0] p_gain;
		logic [3:0]  d_gain;
		logic [6:0]  corr_lim;
		logic [6:0]  motor_lim;
	} cfg_t;

	// Reduced angle of one wheel: quarter-table index and sign of the drive
	typedef struct packed {
		logic       neg;
		logic [6:0] idx;
	} wheel_ang_t;

	// Item handed from the front end to the back end through the queue
	typedef struct packed {
		logic signed [10:0]         p_term;
		logic signed [15:0]         d_term;
		logic [6:0]                 power;
		wheel_ang_t [NUM_WHEELS-1:0] wheel;
	} item_t;

	// round(sin(k deg) * 32768), k = 0..90
	localparam logic [15:0] QUARTER_SINE [SINE_ENTRIES] = '{
		16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,
		16'd2856,  16'd3425,  16'd3993,  16'd4560,  16'd5126,
		16'd5690,  16'd6252,  16'd6813,  16'd7371,  16'd7927,
		16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668,
		16'd11207, 16'd11743, 16'd12275, 16'd12803, 16'd13328,
		16'd13848, 16'd14365, 16'd14876, 16'd15384, 16'd15886,
		16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
		16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622,
		16'd21063, 16'd21498, 16'd21926, 16'd22348, 16'd22763,
		16'd23170, 16'd23571, 16'd23965, 16'd24351, 16'd24730,
		16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510,
		16'd26842, 16'd27166, 16'd27482, 16'd27789, 16'd28088,
		16'd28378, 16'd28660, 16'd28932, 16'd29197, 16'd29452,
		16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
		16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499,
		16'd31651, 16'd31795, 16'd31928, 16'd32052, 16'd32166,
		16'd32270, 16'd32365, 16'd32449, 16'd32524, 16'd32588,
		16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763,
		16'd32768
	};

	function automatic logic [15:0] sine_q15(input logic [6:0] idx);
		logic [6:0] safe;
		safe = (idx <= 7'(QUARTER_TURN)) ? idx : 7'd0;
		return QUARTER_SINE[safe];
	endfunction

endpackage

`default_nettype wire

// ===== src/hpd_front.sv =====
// Front end: accepts input items, forms the P and D products and reduces the wheel angles.
// Depends on hpd_pkg; feeds hpd_fifo.
`default_nettype none

module hpd_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	input  wire logic          full,
	input  wire logic [31:0]   s_tdata,  // gyro_reading[9:0], direction_deg[18:10], drive_power[25:19]
	input  hpd_pkg::cfg_t      cfg,
	output logic               s_tready,
	output logic               push,
	output hpd_pkg::item_t     item
);
	import hpd_pkg::*;

	logic [9:0]         gyro;
	logic [8:0]         dir;
	logic [6:0]         power;
	logic signed [11:0] err;
	logic signed [10:0] e2;
	logic [9:0]         e2_mag;
	logic [25:0]        p_prod;
	logic [9:0]         p_mag;
	logic signed [10:0] dev;
	logic signed [11:0] dev_diff;
	logic signed [16:0] d_prod;
	logic signed [10:0] prev_q;
	logic [9:0]         ang_sum [NUM_WHEELS];
	logic [8:0]         ang_red [NUM_WHEELS];

	assign gyro  = s_tdata[9:0];
	assign dir   = s_tdata[18:10];
	assign power = s_tdata[25:19];

	assign s_tready = !full;
	assign push     = s_tvalid && s_tready;

	// P: fold, double, sign-magnitude product so the shift truncates toward zero
	always_comb begin
		if (gyro > 10'(GYRO_FOLD_THRESH))
			err = $signed({2'b00, gyro}) - 12'sd810;
		else
			err = $signed({2'b00, gyro});
		e2     = 11'(err <<< 1);
		e2_mag = e2[10] ? 10'(-e2) : e2[9:0];
		p_prod = e2_mag * cfg.p_gain;
		p_mag  = p_prod[25:16];
	end

	// D on the negated raw reading
	always_comb begin
		dev      = -$signed({1'b0, gyro});
		dev_diff = 12'(dev) - 12'(prev_q);
		d_prod   = dev_diff * $signed({1'b0, cfg.d_gain});
	end

	always_comb begin
		for (int w = 0; w < NUM_WHEELS; w++) begin
			ang_sum[w] = {1'b0, dir} + {1'b0, WHEEL_OFFSET[w]};
			if (ang_sum[w] >= 10'(2 * FULL_TURN))
				ang_red[w] = 9'(ang_sum[w] - 10'(2 * FULL_TURN));
			else if (ang_sum[w] >= 10'(FULL_TURN))
				ang_red[w] = 9'(ang_sum[w] - 10'(FULL_TURN));
			else
				ang_red[w] = ang_sum[w][8:0];

			if (ang_red[w] <= 9'(QUARTER_TURN)) begin
				item.wheel[w].idx = ang_red[w][6:0];
				item.wheel[w].neg = WHEEL_NEGATE[w];
			end else if (ang_red[w] <= 9'(HALF_TURN)) begin
				item.wheel[w].idx = 7'(9'(HALF_TURN) - ang_red[w]);
				item.wheel[w].neg = WHEEL_NEGATE[w];
			end else if (ang_red[w] <= 9'(THREE_QUARTS)) begin
				item.wheel[w].idx = 7'(ang_red[w] - 9'(HALF_TURN));
				item.wheel[w].neg = !WHEEL_NEGATE[w];
			end else begin
				item.wheel[w].idx = 7'(9'(FULL_TURN) - ang_red[w]);
				item.wheel[w].neg = !WHEEL_NEGATE[w];
			end
		end
		item.p_term = e2[10] ? -$signed({1'b0, p_mag}) : $signed({1'b0, p_mag});
		item.d_term = 16'(d_prod);
		item.power  = power;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			prev_q <= '0;
		else if (push)
			prev_q <= dev;
	end

	a_prev_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!push |=> $stable(prev_q))
		else $error("previous deviation changed without an accepted item");

endmodule

`default_nettype wire

// ===== src/hpd_fifo.sv =====
// Short queue between front and back end, one entry per accepted item.
// Depends on hpd_pkg for the entry type.
`default_nettype none

module hpd_fifo #(
	parameter int DEPTH = hpd_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  hpd_pkg::item_t wr_item,
	input  wire logic      pop,
	output hpd_pkg::item_t rd_item,
	output logic           full,
	output logic           empty
);
	import hpd_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	item_t         mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign rd_item = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == CW'($past(count_q) + 1'b1))
		else $error("queue count lost an item");

endmodule

`default_nettype wire

// ===== src/hpd_back.sv =====
// Back end: clamps the correction, scales the sine drives, mixes and encodes the wheels.
// Two pipeline stages; depends on hpd_pkg, drains hpd_fifo.
`default_nettype none

module hpd_back #(
	parameter int SINE_FRAC_BITS = hpd_pkg::SINE_FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         empty,
	input  hpd_pkg::item_t    item,
	input  hpd_pkg::cfg_t     cfg,
	output logic              pop,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [39:0]       m_tdata  // wheel0_pwm[7:0], wheel1_pwm[15:8], wheel2_pwm[23:16],
	                                   // wheel3_pwm[31:24], correction[39:32]
);
	import hpd_pkg::*;

	localparam int SW   = SINE_FRAC_BITS + 1;
	localparam int DOWN = (SINE_FRAC_BITS < 15) ? 15 - SINE_FRAC_BITS : 0;
	localparam int UP   = (SINE_FRAC_BITS > 15) ? SINE_FRAC_BITS - 15 : 0;
	localparam logic [31:0] RND = (32'd1 << DOWN) >> 1;

	logic              adv_s1;
	logic              adv_s2;
	logic              valid_s1;
	logic              valid_s2;

	logic signed [16:0] corr_sum;
	logic signed [16:0] corr_lim;
	logic signed [7:0]  corr_c;
	logic [31:0]        sine_w   [NUM_WHEELS];
	logic [SW-1:0]      sine_s   [NUM_WHEELS];
	logic [SW+6:0]      prod     [NUM_WHEELS];
	logic [6:0]         mag      [NUM_WHEELS];
	logic signed [7:0]  drive_c  [NUM_WHEELS];

	logic signed [7:0]  drive_s1 [NUM_WHEELS];
	logic signed [7:0]  corr_s1;

	logic signed [8:0]  mix      [NUM_WHEELS];
	logic signed [8:0]  mlim;
	logic signed [8:0]  wclamp   [NUM_WHEELS];
	logic [7:0]         pwm_c    [NUM_WHEELS];

	logic [7:0]         pwm_s2   [NUM_WHEELS];
	logic [7:0]         corr_s2;

	assign adv_s2 = !valid_s2 || m_tready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign pop    = !empty && adv_s1;

	// Stage 1: correction clamp and the four sine products
	always_comb begin
		corr_sum = 17'(item.p_term) + 17'(item.d_term);
		corr_lim = $signed({10'd0, cfg.corr_lim});
		if (corr_sum > corr_lim)
			corr_c = 8'(corr_lim);
		else if (corr_sum < -corr_lim)
			corr_c = 8'(-corr_lim);
		else
			corr_c = 8'(corr_sum);

		for (int w = 0; w < NUM_WHEELS; w++) begin
			// table value rounded half up, or widened, to the working fraction
			sine_w[w]  = ((32'(sine_q15(item.wheel[w].idx)) + RND) >> DOWN) << UP;
			sine_s[w]  = sine_w[w][SW-1:0];
			prod[w]    = sine_s[w] * item.power;
			mag[w]     = prod[w][SINE_FRAC_BITS+6:SINE_FRAC_BITS];
			drive_c[w] = item.wheel[w].neg ? -$signed({1'b0, mag[w]}) : $signed({1'b0, mag[w]});
		end
	end

	// Stage 2: mix, clamp, sign-magnitude (zero always leaves as 0x00)
	always_comb begin
		mlim = $signed({2'b00, cfg.motor_lim});
		for (int w = 0; w < NUM_WHEELS; w++) begin
			if (w == 0 || w == 2)
				mix[w] = 9'(drive_s1[w]) + 9'(corr_s1);
			else
				mix[w] = 9'(drive_s1[w]) - 9'(corr_s1);
			if (mix[w] > mlim)
				wclamp[w] = mlim;
			else if (mix[w] < -mlim)
				wclamp[w] = -mlim;
			else
				wclamp[w] = mix[w];
			if (wclamp[w] < 0)
				pwm_c[w] = {1'b1, 7'(-wclamp[w])};
			else
				pwm_c[w] = {1'b0, wclamp[w][6:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= !empty;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			drive_s1 <= drive_c;
			corr_s1  <= corr_c;
		end
		if (adv_s2 && valid_s1) begin
			pwm_s2  <= pwm_c;
			corr_s2 <= corr_s1;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {corr_s2, pwm_s2[3], pwm_s2[2], pwm_s2[1], pwm_s2[0]};

endmodule

`default_nettype wire

// ===== src/heading_pd_omni_drive.sv =====
// Heading-hold PD correction mixed into a four-wheel omni drive (top level).
// Holds the configuration registers; instantiates hpd_front, hpd_fifo and hpd_back.
//
// One item in, one result out. The block takes an item every cycle while the queue is
// not full; after its item is accepted, a result passes the queue and then two back-end
// stages, and back-pressure on the result side is absorbed by the queue of
// FIFO_DEPTH entries before the input stalls. The only value carried from item to
// item is the previous deviation, updated in the accept cycle. Configuration may
// only change while no item is in flight.
`default_nettype none

module heading_pd_omni_drive #(
	parameter int SINE_FRAC_BITS = hpd_pkg::SINE_FRAC_BITS_DEF,
	parameter int FIFO_DEPTH     = hpd_pkg::FIFO_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // gyro_reading[9:0], direction_deg[18:10],
	                                    // drive_power[25:19], zero fill above
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // wheel0_pwm[7:0], wheel1_pwm[15:8], wheel2_pwm[23:16],
	                                    // wheel3_pwm[31:24], correction[39:32]
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	import hpd_pkg::*;

	cfg_t  cfg_q;
	item_t fr_item;
	item_t bk_item;
	logic  push;
	logic  pop;
	logic  full;
	logic  empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.p_gain    <= P_GAIN_RST;
			cfg_q.d_gain    <= D_GAIN_RST;
			cfg_q.corr_lim  <= CORR_LIM_RST;
			cfg_q.motor_lim <= MOTOR_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_P_GAIN:    cfg_q.p_gain    <= cfg_wdata;
				CFG_D_GAIN:    cfg_q.d_gain    <= cfg_wdata[3:0];
				CFG_CORR_LIM:  cfg_q.corr_lim  <= cfg_wdata[6:0];
				CFG_MOTOR_LIM: cfg_q.motor_lim <= cfg_wdata[6:0];
				default: ;
			endcase
		end
	end

	hpd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.full     (full),
		.s_tdata  (s_tdata),
		.cfg      (cfg_q),
		.s_tready (s_tready),
		.push     (push),
		.item     (fr_item)
	);

	hpd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (fr_item),
		.pop     (pop),
		.rd_item (bk_item),
		.full    (full),
		.empty   (empty)
	);

	hpd_back #(
		.SINE_FRAC_BITS (SINE_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.item     (bk_item),
		.cfg      (cfg_q),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

`default_nettype wire
